/* rtl/core/sallru_pkg.sv */
// Shared constants, codes and types of the set-associative LRU tag store.
package sallru_pkg;

    // Default sizing handed to the top level.
    localparam int unsigned DEF_MAX_SETS   = 256;
    localparam int unsigned DEF_MAX_WAYS   = 8;
    localparam int unsigned DEF_ADDR_WIDTH = 32;

    // Fixed port widths.
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned SIZE_W    = 4;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned TAG_W     = 32;
    localparam int unsigned SETNUM_W  = 8;
    localparam int unsigned OFFSET_W  = 12;
    localparam int unsigned WAYNUM_W  = 3;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned CFG_DATA_W  = 4;
    localparam int unsigned CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    // Configuration reset values and limits.
    localparam logic [CFG_DATA_W-1:0] RST_INDEX_BITS  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] RST_OFFSET_BITS = 4'd4;
    localparam logic [CFG_DATA_W-1:0] RST_WAYS_IN_USE = 4'd8;
    localparam logic [CFG_DATA_W-1:0] OFFSET_LIMIT    = 4'd12;

    // Access commands.
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // Outcome flags of a set scan.
    typedef struct packed {
        logic hit;
        logic free;
    } scan_flags_t;

    // Only 1, 2, 4 and 8 byte references are serviced.
    function automatic logic size_ok(input logic [SIZE_W-1:0] size);
        return (size == 4'd1) || (size == 4'd2) || (size == 4'd4) || (size == 4'd8);
    endfunction

endpackage

/* rtl/core/sallru_store.sv */
// Tag, stamp and valid-row memories of the tag store.
module sallru_store #(
    parameter int unsigned MAX_SETS = 256,
    parameter int unsigned MAX_WAYS = 8,
    localparam int unsigned LINES  = MAX_SETS * MAX_WAYS,
    localparam int unsigned LINE_W = (LINES > 1) ? $clog2(LINES) : 1,
    localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                clk,
    // Line port: one tag and stamp per line.
    input  logic                line_rd_en,
    input  logic [LINE_W-1:0]   line_rd_addr,
    output logic [31:0]         line_rd_tag,
    output logic [31:0]         line_rd_stamp,
    input  logic                line_wr_en,
    input  logic                line_wr_tag_en,
    input  logic [LINE_W-1:0]   line_wr_addr,
    input  logic [31:0]         line_wr_tag,
    input  logic [31:0]         line_wr_stamp,
    // Row port: the valid bits of all ways of one set.
    input  logic                row_rd_en,
    input  logic [SET_W-1:0]    row_rd_addr,
    output logic [MAX_WAYS-1:0] row_rd_data,
    input  logic                row_wr_en,
    input  logic [SET_W-1:0]    row_wr_addr,
    input  logic [MAX_WAYS-1:0] row_wr_data
);

    logic [31:0]         tag_mem   [LINES];
    logic [31:0]         stamp_mem [LINES];
    logic [MAX_WAYS-1:0] row_mem   [MAX_SETS];

    // Line memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (line_wr_en)
        begin
            stamp_mem[line_wr_addr] <= line_wr_stamp;
        end
        if (line_wr_tag_en)
        begin
            tag_mem[line_wr_addr] <= line_wr_tag;
        end
        if (line_rd_en)
        begin
            line_rd_tag   <= tag_mem[line_rd_addr];
            line_rd_stamp <= stamp_mem[line_rd_addr];
        end
    end

    // Valid-row memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (row_wr_en)
        begin
            row_mem[row_wr_addr] <= row_wr_data;
        end
        if (row_rd_en)
        begin
            row_rd_data <= row_mem[row_rd_addr];
        end
    end

endmodule

/* rtl/core/sallru_scan.sv */
// Shared compare unit that walks the ways of a set one per cycle.
module sallru_scan
    import sallru_pkg::*;
#(
    parameter int unsigned MAX_WAYS = 8,
    localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             first,
    input  logic [WAY_W-1:0] step_way,
    input  logic             line_ok,
    input  logic [31:0]      line_tag,
    input  logic [31:0]      line_stamp,
    input  logic [31:0]      key_tag,
    output scan_flags_t      flags,
    output logic [WAY_W-1:0] hit_way,
    output logic [WAY_W-1:0] free_way,
    output logic [WAY_W-1:0] old_way,
    output logic [31:0]      old_tag
);

    scan_flags_t      flags_reg, flags_next;
    logic [WAY_W-1:0] hit_way_reg, hit_way_next;
    logic [WAY_W-1:0] free_way_reg, free_way_next;
    logic [WAY_W-1:0] old_way_reg, old_way_next;
    logic [31:0]      old_tag_reg, old_tag_next;
    logic [31:0]      min_stamp_reg, min_stamp_next;
    logic             match;
    logic             older;

    // One tag equality and one stamp compare serve every way in turn.
    assign match = line_ok && (line_tag == key_tag);
    assign older = line_stamp < min_stamp_reg;

    // Keep the lowest hit, the lowest free way and the oldest stamp.
    always_comb
    begin
        flags_next     = flags_reg;
        hit_way_next   = hit_way_reg;
        free_way_next  = free_way_reg;
        old_way_next   = old_way_reg;
        old_tag_next   = old_tag_reg;
        min_stamp_next = min_stamp_reg;
        if (step)
        begin
            if (first)
            begin
                flags_next.hit  = match;
                flags_next.free = !line_ok;
                hit_way_next    = step_way;
                free_way_next   = step_way;
                old_way_next    = step_way;
                old_tag_next    = line_tag;
                min_stamp_next  = line_stamp;
            end
            else
            begin
                if (match && !flags_reg.hit)
                begin
                    flags_next.hit = 1'b1;
                    hit_way_next   = step_way;
                end
                if (!line_ok && !flags_reg.free)
                begin
                    flags_next.free = 1'b1;
                    free_way_next   = step_way;
                end
                if (older)
                begin
                    old_way_next   = step_way;
                    old_tag_next   = line_tag;
                    min_stamp_next = line_stamp;
                end
            end
        end
    end

    // Scan flags are control state; the rest is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_way_reg   <= hit_way_next;
        free_way_reg  <= free_way_next;
        old_way_reg   <= old_way_next;
        old_tag_reg   <= old_tag_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign flags    = flags_reg;
    assign hit_way  = hit_way_reg;
    assign free_way = free_way_reg;
    assign old_way  = old_way_reg;
    assign old_tag  = old_tag_reg;

endmodule

/* rtl/core/set_assoc_lru_cache_tags_core.sv */
// Top level of the set-associative tag store with timestamp LRU replacement.
//
//  Channel   Handshake             Payload
//  -------   -------------------   -------------------------------------------------
//  access    start & !busy         command, access_size, address
//  result    done (one cycle)      status, tag_value, set_number, line_offset,
//                                  way_used, evicted, evicted_tag, hit_total, miss_total
//  config    cfg_write             cfg_index, cfg_data
//
// A serviced access keeps busy high after its transfer while it is serviced:
// one compare unit walks the ways of the set one per cycle over the line memory
// port, then the update state writes tag, stamp and valid row. done rises in the cycle
// after that, together with busy falling. An ignored access gives its result in
// the next cycle and leaves busy low. After reset a clearing pass zeroes the
// valid rows with busy high. The result receiver cannot stall.
module set_assoc_lru_cache_tags_core
    import sallru_pkg::*;
#(
    parameter int unsigned MAX_SETS   = DEF_MAX_SETS,
    parameter int unsigned MAX_WAYS   = DEF_MAX_WAYS,
    parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [CMD_W-1:0]       command,
    input  logic [SIZE_W-1:0]      access_size,
    input  logic [ADDR_W-1:0]      address,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   done,
    output logic [STATUS_W-1:0]    status,
    output logic [TAG_W-1:0]       tag_value,
    output logic [SETNUM_W-1:0]    set_number,
    output logic [OFFSET_W-1:0]    line_offset,
    output logic [WAYNUM_W-1:0]    way_used,
    output logic                   evicted,
    output logic [TAG_W-1:0]       evicted_tag,
    output logic [COUNT_W-1:0]     hit_total,
    output logic [COUNT_W-1:0]     miss_total
);

    localparam int unsigned SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int unsigned LINES   = MAX_SETS * MAX_WAYS;
    localparam int unsigned LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int unsigned IDX_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam logic [ADDR_W-1:0] AMASK =
        (ADDR_WIDTH >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    // Sequencer states.
    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    typedef logic [MAX_WAYS-1:0] row_t;

    logic [1:0]            state_reg, state_next;
    logic [SET_W-1:0]      clr_cnt_reg;
    logic [WCNT_W-1:0]     issue_cnt_reg;
    logic [WCNT_W-1:0]     nw_reg;
    logic                  rd_vld_reg;
    logic [WAY_W-1:0]      rd_way_reg;
    logic [STAMP_W-1:0]    clock_reg;
    logic [STAMP_W-1:0]    now_reg;
    logic [COUNT_W-1:0]    hit_cnt_reg;
    logic [COUNT_W-1:0]    miss_cnt_reg;
    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [WAYNUM_W-1:0]   way_reg;
    logic                  evicted_reg;
    logic [TAG_W-1:0]      evtag_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [SET_W-1:0]      set_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [CFG_DATA_W-1:0] index_bits_reg;
    logic [CFG_DATA_W-1:0] offset_bits_reg;
    logic [CFG_DATA_W-1:0] ways_reg;

    logic                  accept;
    logic                  op_ok;
    logic [CFG_DATA_W-1:0] ib_eff;
    logic [CFG_DATA_W-1:0] ob_eff;
    logic [4:0]            nw_wide;
    logic [WCNT_W-1:0]     nw_eff;
    logic [ADDR_W-1:0]     addr_m;
    logic [ADDR_W-1:0]     off_full;
    logic [ADDR_W-1:0]     set_full;
    logic [ADDR_W-1:0]     tag_full;
    logic [4:0]            tag_shift;
    logic                  issuing;
    logic                  scan_last;
    logic [WAY_W-1:0]      issue_way;
    logic [LINE_W-1:0]     line_base;
    logic [WAY_W-1:0]      fin_way;
    logic                  do_update;

    logic [31:0]           rd_tag;
    logic [31:0]           rd_stamp;
    row_t                  row_q;
    logic                  row_wr_en;
    logic [SET_W-1:0]      row_wr_addr;
    row_t                  row_wr_data;

    scan_flags_t           flags;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      old_way;
    logic [31:0]           old_tag;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign op_ok  = ((command == CMD_READ) || (command == CMD_WRITE)) && size_ok(access_size);

    // Configuration writes, taken whenever the enable is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg  <= RST_INDEX_BITS;
            offset_bits_reg <= RST_OFFSET_BITS;
            ways_reg        <= RST_WAYS_IN_USE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                REG_WAYS_IN_USE: ways_reg        <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Saturate the field widths and the associativity.
    assign ib_eff  = (index_bits_reg > CFG_DATA_W'(IDX_MAX)) ? CFG_DATA_W'(IDX_MAX)
                                                              : index_bits_reg;
    assign ob_eff  = (offset_bits_reg > OFFSET_LIMIT) ? OFFSET_LIMIT : offset_bits_reg;
    assign nw_wide = (ways_reg == '0) ? 5'd1
                   : ({1'b0, ways_reg} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : {1'b0, ways_reg};
    assign nw_eff  = WCNT_W'(nw_wide);

    // Split the address into offset, set and tag.
    assign addr_m    = address & AMASK;
    assign off_full  = addr_m & ((ADDR_W'(1) << ob_eff) - ADDR_W'(1));
    assign set_full  = (addr_m >> ob_eff) & ((ADDR_W'(1) << ib_eff) - ADDR_W'(1));
    assign tag_shift = {1'b0, ob_eff} + {1'b0, ib_eff};
    assign tag_full  = addr_m >> tag_shift;

    // Way reads are issued in order; the data returns in the next cycle.
    assign issuing   = (state_reg == S_SCAN) && (issue_cnt_reg < nw_reg);
    assign issue_way = issue_cnt_reg[WAY_W-1:0];
    assign scan_last = rd_vld_reg && (WCNT_W'(rd_way_reg) == (nw_reg - WCNT_W'(1)));
    assign line_base = LINE_W'(set_reg) * LINE_W'(MAX_WAYS);

    // Pick the way to refresh or fill once the scan is complete.
    assign do_update = (state_reg == S_UPDATE);
    always_comb
    begin
        if (flags.hit)
        begin
            fin_way = hit_way;
        end
        else if (flags.free)
        begin
            fin_way = free_way;
        end
        else
        begin
            fin_way = old_way;
        end
    end

    // Row writes: zeros during the clearing pass, else mark the filled way.
    assign row_wr_en   = (state_reg == S_CLEAR) || (do_update && !flags.hit);
    assign row_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : set_reg;
    assign row_wr_data = (state_reg == S_CLEAR) ? '0 : (row_q | (row_t'(1) << fin_way));

    sallru_store #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_store (
        .clk            (clk),
        .line_rd_en     (issuing),
        .line_rd_addr   (line_base + LINE_W'(issue_way)),
        .line_rd_tag    (rd_tag),
        .line_rd_stamp  (rd_stamp),
        .line_wr_en     (do_update),
        .line_wr_tag_en (do_update && !flags.hit),
        .line_wr_addr   (line_base + LINE_W'(fin_way)),
        .line_wr_tag    (tag_reg),
        .line_wr_stamp  (now_reg),
        .row_rd_en      (issuing && (issue_cnt_reg == '0)),
        .row_rd_addr    (set_reg),
        .row_rd_data    (row_q),
        .row_wr_en      (row_wr_en),
        .row_wr_addr    (row_wr_addr),
        .row_wr_data    (row_wr_data)
    );

    sallru_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (rd_vld_reg),
        .first      (rd_way_reg == '0),
        .step_way   (rd_way_reg),
        .line_ok    (row_q[rd_way_reg]),
        .line_tag   (rd_tag),
        .line_stamp (rd_stamp),
        .key_tag    (tag_reg),
        .flags      (flags),
        .hit_way    (hit_way),
        .free_way   (free_way),
        .old_way    (old_way),
        .old_tag    (old_tag)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && op_ok)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, counters and the access clock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            clock_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issuing;
            done_reg   <= (accept && !op_ok) || do_update;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (accept)
            begin
                clock_reg     <= clock_reg + STAMP_W'(1);
                issue_cnt_reg <= '0;
            end
            else if (issuing)
            begin
                issue_cnt_reg <= issue_cnt_reg + WCNT_W'(1);
            end
            if (do_update)
            begin
                if (flags.hit)
                begin
                    hit_cnt_reg <= hit_cnt_reg + COUNT_W'(1);
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + COUNT_W'(1);
                end
            end
        end
    end

    // Access fields and result payload.
    always_ff @(posedge clk)
    begin
        if (issuing)
        begin
            rd_way_reg <= issue_way;
        end
        if (accept)
        begin
            now_reg    <= clock_reg;
            nw_reg     <= nw_eff;
            tag_reg    <= tag_full;
            set_reg    <= SET_W'(set_full);
            offset_reg <= OFFSET_W'(off_full);
            if (!op_ok)
            begin
                status_reg  <= ST_IGNORED;
                way_reg     <= '0;
                evicted_reg <= 1'b0;
                evtag_reg   <= '0;
            end
        end
        else if (do_update)
        begin
            status_reg  <= flags.hit ? ST_HIT : ST_MISS;
            way_reg     <= WAYNUM_W'(fin_way);
            evicted_reg <= !flags.hit && !flags.free;
            evtag_reg   <= (!flags.hit && !flags.free) ? old_tag : '0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign tag_value   = tag_reg;
    assign set_number  = SETNUM_W'(set_reg);
    assign line_offset = offset_reg;
    assign way_used    = way_reg;
    assign evicted     = evicted_reg;
    assign evicted_tag = evtag_reg;
    assign hit_total   = hit_cnt_reg;
    assign miss_total  = miss_cnt_reg;

endmodule

/* rtl/core/sallru_checker.sv */
// Port-level checks of the tag store, bound to the top level.
module sallru_checker
    import sallru_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [CMD_W-1:0]    command,
    input logic [SIZE_W-1:0]   access_size,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [WAYNUM_W-1:0] way_used,
    input logic                evicted,
    input logic [TAG_W-1:0]    evicted_tag,
    input logic [COUNT_W-1:0]  hit_total,
    input logic [COUNT_W-1:0]  miss_total
);

    // A serviced access transfer makes the block busy in the next cycle.
    a_busy_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((command == CMD_READ) || (command == CMD_WRITE))
            && size_ok(access_size) |=> busy)
        else $error("serviced access did not raise busy");

    // A hit never replaces a line.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_HIT) |-> !evicted && (evicted_tag == '0))
        else $error("hit reported an eviction");

    // An ignored access reports no way and no eviction, and counts nothing.
    a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_IGNORED) |-> (way_used == '0) && !evicted
            && $stable(hit_total) && $stable(miss_total))
        else $error("ignored access changed way, eviction or counters");

    // Each hit or miss result moves the sum of the two totals by exactly one.
    a_totals_step: assert property (@(posedge clk) disable iff (!rst_n)
        done && ((status == ST_HIT) || (status == ST_MISS)) |->
            (COUNT_W'(hit_total + miss_total)
                == COUNT_W'($past(hit_total) + $past(miss_total) + COUNT_W'(1))))
        else $error("hit and miss totals out of step with results");

endmodule

bind set_assoc_lru_cache_tags_core sallru_checker u_sallru_checker (.*);

/* bench/set_assoc_lru_cache_tags_core_test.sv */
// Self-checking bench for the set-associative tag store core with timestamp LRU replacement.
module set_assoc_lru_cache_tags_core_test
    import sallru_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINES       = DEF_MAX_SETS * DEF_MAX_WAYS;
    localparam int unsigned INDEX_LIMIT = $clog2(DEF_MAX_SETS);
    localparam int unsigned DRAIN       = DEF_MAX_WAYS + 8;
    localparam int unsigned GAP_PCT     = 24;

    // Command codes the core does not service.
    localparam logic [CMD_W-1:0] CMD_OTHER = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Register index with no register behind it.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } access_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag_value;
        logic [SETNUM_W-1:0] set_number;
        logic [OFFSET_W-1:0] line_offset;
        logic [WAYNUM_W-1:0] way_used;
        logic                evicted;
        logic [TAG_W-1:0]    evicted_tag;
        logic [COUNT_W-1:0]  hit_total;
        logic [COUNT_W-1:0]  miss_total;
    } result_t;

    // Effective field widths after saturation of the registers.
    typedef struct packed {
        logic [4:0] ib;
        logic [4:0] ob;
        logic [4:0] nw;
    } geometry_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_W-1:0]       command;
    logic [SIZE_W-1:0]      access_size;
    logic [ADDR_W-1:0]      address;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [TAG_W-1:0]       tag_value;
    logic [SETNUM_W-1:0]    set_number;
    logic [OFFSET_W-1:0]    line_offset;
    logic [WAYNUM_W-1:0]    way_used;
    logic                   evicted;
    logic [TAG_W-1:0]       evicted_tag;
    logic [COUNT_W-1:0]     hit_total;
    logic [COUNT_W-1:0]     miss_total;

    // Shadow copy of the tag store and its registers.
    bit                  way_valid [LINES];
    logic [TAG_W-1:0]    way_tag   [LINES];
    logic [STAMP_W-1:0]  way_stamp [LINES];
    logic [STAMP_W-1:0]  stamp_clock;
    logic [COUNT_W-1:0]  hit_count;
    logic [COUNT_W-1:0]  miss_count;
    logic [CFG_DATA_W-1:0] index_bits_reg;
    logic [CFG_DATA_W-1:0] offset_bits_reg;
    logic [CFG_DATA_W-1:0] ways_reg;

    access_t     access_queue [$];
    result_t     outcomes_due [$];
    access_t     next_access;
    int unsigned accesses_queued;
    int unsigned transfers_seen;
    int unsigned gap_pct;
    bit          took;
    bit          failed;

    set_assoc_lru_cache_tags_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .access_size (access_size),
        .address     (address),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .tag_value   (tag_value),
        .set_number  (set_number),
        .line_offset (line_offset),
        .way_used    (way_used),
        .evicted     (evicted),
        .evicted_tag (evicted_tag),
        .hit_total   (hit_total),
        .miss_total  (miss_total)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Saturate the registers the way the core interprets them.
    function automatic geometry_t cache_geometry();
        geometry_t g;
        g.ib = (index_bits_reg > INDEX_LIMIT) ? 5'(INDEX_LIMIT) : 5'(index_bits_reg);
        g.ob = (offset_bits_reg > OFFSET_LIMIT) ? 5'(OFFSET_LIMIT) : 5'(offset_bits_reg);
        if (ways_reg == 0)
            g.nw = 5'd1;
        else if (ways_reg > DEF_MAX_WAYS)
            g.nw = 5'(DEF_MAX_WAYS);
        else
            g.nw = 5'(ways_reg);
        return g;
    endfunction

    // Build an address from tag, set and offset under the current geometry.
    function automatic logic [ADDR_W-1:0] make_addr(logic [31:0] tag, int unsigned set_idx,
                                                    logic [31:0] off);
        geometry_t   g;
        logic [63:0] wide;
        g = cache_geometry();
        wide = ({32'd0, tag} << (g.ob + g.ib))
             | ((64'(set_idx) & ((64'd1 << g.ib) - 64'd1)) << g.ob)
             | (64'(off) & ((64'd1 << g.ob) - 64'd1));
        return wide[ADDR_W-1:0];
    endfunction

    // Look up one access in the shadow store, update it and return the result.
    function automatic result_t service_access(access_t a);
        geometry_t   g;
        result_t     r;
        logic [63:0] wide;
        logic [31:0] tag;
        logic [31:0] now;
        int unsigned set_idx;
        int unsigned base;
        int unsigned way;
        bit          size_valid;
        bit          hit_found;
        bit          free_found;
        g = cache_geometry();
        wide = {32'd0, a.addr};
        set_idx = 32'((wide >> g.ob) & ((64'd1 << g.ib) - 64'd1));
        tag = 32'(wide >> (g.ob + g.ib));
        r = '0;
        r.status = ST_IGNORED;
        r.tag_value = tag;
        r.set_number = SETNUM_W'(set_idx);
        r.line_offset = OFFSET_W'(wide & ((64'd1 << g.ob) - 64'd1));
        now = stamp_clock;
        stamp_clock = stamp_clock + 32'd1;
        size_valid = (a.size == 4'd1) || (a.size == 4'd2)
                  || (a.size == 4'd4) || (a.size == 4'd8);
        if (size_valid && (a.cmd == CMD_READ || a.cmd == CMD_WRITE))
        begin
            base = set_idx * DEF_MAX_WAYS;
            hit_found = 1'b0;
            free_found = 1'b0;
            way = 0;
            for (int unsigned w = 0; w < g.nw; w++)
            begin
                if (!hit_found && way_valid[base + w] && way_tag[base + w] == tag)
                begin
                    hit_found = 1'b1;
                    way = w;
                end
            end
            if (hit_found)
            begin
                r.status = ST_HIT;
                hit_count = hit_count + 32'd1;
            end
            else
            begin
                r.status = ST_MISS;
                miss_count = miss_count + 32'd1;
                for (int unsigned w = 0; w < g.nw; w++)
                begin
                    if (!free_found && !way_valid[base + w])
                    begin
                        free_found = 1'b1;
                        way = w;
                    end
                end
                // No free way: the oldest stamp loses, lowest way on a tie.
                if (!free_found)
                begin
                    way = 0;
                    for (int unsigned w = 1; w < g.nw; w++)
                        if (way_stamp[base + w] < way_stamp[base + way])
                            way = w;
                    r.evicted = 1'b1;
                    r.evicted_tag = way_tag[base + way];
                end
                way_valid[base + way] = 1'b1;
                way_tag[base + way] = tag;
            end
            way_stamp[base + way] = now;
            r.way_used = WAYNUM_W'(way);
        end
        r.hit_total = hit_count;
        r.miss_total = miss_count;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // Driver: offers the next queued access at the falling edge, with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || took)
        begin
            took = 1'b0;
            if (access_queue.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                next_access = access_queue.pop_front();
                start <= 1'b1;
                command <= next_access.cmd;
                access_size <= next_access.size;
                address <= next_access.addr;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each result strobe and predicts each accepted transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $error("result strobe with no access outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    result_t want;
                    want = outcomes_due.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("tag_value", want.tag_value, tag_value);
                    compare_field("set_number", 32'(want.set_number), 32'(set_number));
                    compare_field("line_offset", 32'(want.line_offset), 32'(line_offset));
                    compare_field("way_used", 32'(want.way_used), 32'(way_used));
                    compare_field("evicted", 32'(want.evicted), 32'(evicted));
                    compare_field("evicted_tag", want.evicted_tag, evicted_tag);
                    compare_field("hit_total", want.hit_total, hit_total);
                    compare_field("miss_total", want.miss_total, miss_total);
                end
            end
            if (start && !busy)
            begin
                outcomes_due.push_back(service_access('{command, access_size, address}));
                transfers_seen++;
                took = 1'b1;
            end
        end
    end

    task automatic enqueue(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                           logic [ADDR_W-1:0] addr);
        access_queue.push_back('{cmd, size, addr});
        accesses_queued++;
    endtask

    // Wait until every queued access has been transferred and answered.
    task automatic settle();
        while (transfers_seen != accesses_queued || outcomes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_INDEX_BITS)
            index_bits_reg = data;
        else if (idx == REG_OFFSET_BITS)
            offset_bits_reg = data;
        else if (idx == REG_WAYS_IN_USE)
            ways_reg = data;
    endtask

    // Drain the core, then load a new geometry.
    task automatic reconfigure(logic [3:0] ib, logic [3:0] ob, logic [3:0] nw, int unsigned gap);
        settle();
        write_reg(REG_INDEX_BITS, ib);
        write_reg(REG_OFFSET_BITS, ob);
        write_reg(REG_WAYS_IN_USE, nw);
        if ($urandom_range(1))
            write_reg(REG_UNUSED, 4'($urandom));
        @(negedge clk);
        cfg_write <= 1'b0;
        gap_pct = gap;
    endtask

    // Mostly accesses to a few hot sets with a small tag pool, plus noise.
    task automatic queue_random(int unsigned count);
        geometry_t         g;
        logic [31:0]       tag_pool [12];
        int unsigned       set_pool [3];
        int unsigned       ntags;
        int unsigned       nsets;
        int unsigned       roll;
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] size;
        g = cache_geometry();
        ntags = g.nw + 1 + $urandom_range(2);
        nsets = 1 + $urandom_range(2);
        foreach (tag_pool[i])
            tag_pool[i] = $urandom;
        foreach (set_pool[i])
            set_pool[i] = $urandom_range((1 << g.ib) - 1);
        repeat (count)
        begin
            roll = $urandom_range(99);
            cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            size = 4'd1 << $urandom_range(3);
            if (roll < 75)
            begin
                enqueue(cmd, size, make_addr(tag_pool[$urandom_range(ntags - 1)],
                                             set_pool[$urandom_range(nsets - 1)], $urandom));
            end
            else if (roll < 88)
            begin
                enqueue(cmd, size, $urandom);
            end
            else if ($urandom_range(1))
            begin
                enqueue($urandom_range(1) ? CMD_SPARE : CMD_OTHER, 4'($urandom), $urandom);
            end
            else
            begin
                do
                    size = 4'($urandom);
                while (size == 4'd1 || size == 4'd2 || size == 4'd4 || size == 4'd8);
                enqueue(2'($urandom), size, $urandom);
            end
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_READ;
        access_size = '0;
        address = '0;
        cfg_write = 1'b0;
        cfg_index = REG_INDEX_BITS;
        cfg_data = '0;
        stamp_clock = '0;
        hit_count = '0;
        miss_count = '0;
        index_bits_reg = RST_INDEX_BITS;
        offset_bits_reg = RST_OFFSET_BITS;
        ways_reg = RST_WAYS_IN_USE;
        accesses_queued = 0;
        transfers_seen = 0;
        gap_pct = GAP_PCT;
        took = 1'b0;
        failed = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Address extremes: a fill and a hit at each end of the space.
        enqueue(CMD_READ, 4'd1, 32'h0000_0000);
        enqueue(CMD_WRITE, 4'd8, 32'h0000_000F);
        enqueue(CMD_READ, 4'd2, 32'hFFFF_FFFF);
        enqueue(CMD_WRITE, 4'd4, 32'hFFFF_FFF0);
        // Ignored accesses: bad sizes and unserviced commands.
        enqueue(CMD_READ, 4'd0, 32'h1234_5678);
        enqueue(CMD_WRITE, 4'd3, 32'h8765_4321);
        enqueue(CMD_READ, 4'd15, 32'hFFFF_FFFF);
        enqueue(CMD_OTHER, 4'd4, 32'h0000_0050);
        enqueue(CMD_SPARE, 4'd8, 32'h0000_0050);
        // Fill one set completely, then evict the oldest way, refresh another and evict again.
        for (int unsigned t = 1; t <= DEF_MAX_WAYS; t++)
            enqueue((t % 2) ? CMD_READ : CMD_WRITE, 4'd4, make_addr(t, 5, t));
        enqueue(CMD_READ, 4'd1, make_addr(9, 5, 0));
        enqueue(CMD_WRITE, 4'd2, make_addr(2, 5, 3));
        enqueue(CMD_READ, 4'd8, make_addr(10, 5, 0));
        enqueue(CMD_WRITE, 4'd1, make_addr(1, 5, 7));

        // Random phases across several geometries, extremes included.
        reconfigure(4'd0, 4'd0, 4'd1, GAP_PCT);
        queue_random(72);
        reconfigure(4'd15, 4'd15, 4'd0, GAP_PCT);
        queue_random(72);
        reconfigure(4'd2, 4'd3, 4'd4, 0);
        queue_random(72);
        reconfigure(4'd1, 4'd12, 4'd8, GAP_PCT);
        queue_random(72);
        reconfigure(4'd3, 4'd6, 4'd15, GAP_PCT);
        queue_random(72);
        reconfigure(4'd8, 4'd0, 4'd2, GAP_PCT);
        queue_random(72);

        settle();
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sallru_pkg.sv
rtl/core/sallru_store.sv
rtl/core/sallru_scan.sv
rtl/core/set_assoc_lru_cache_tags_core.sv
rtl/core/sallru_checker.sv
bench/set_assoc_lru_cache_tags_core_test.sv
